// ===== hdl/rtpjb_pkg.sv =====
// Package for the RTP reorder jitter buffer: transaction structs, slot entry,
// item kinds, result status codes and the sequencer state type.
// No dependencies.
package rtpjb_pkg;

   localparam logic [1:0] KIND_ARRIVAL = 2'd0;
   localparam logic [1:0] KIND_PULL    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [3:0] STATUS_STORED   = 4'd0;
   localparam logic [3:0] STATUS_REANCHOR = 4'd1;
   localparam logic [3:0] STATUS_LATE     = 4'd2;
   localparam logic [3:0] STATUS_DUP      = 4'd3;
   localparam logic [3:0] STATUS_INVALID  = 4'd4;
   localparam logic [3:0] STATUS_DELIVER  = 4'd5;
   localparam logic [3:0] STATUS_CONCEAL  = 4'd6;
   localparam logic [3:0] STATUS_NOTHING  = 4'd7;
   localparam logic [3:0] STATUS_CLEARED  = 4'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] seq;
      logic [11:0] payload_len;
      logic [15:0] payload_handle;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] out_seq;
      logic [10:0] out_len;
      logic [15:0] out_handle;
      logic [4:0]  queued;
   } rsp_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [10:0] len;
      logic [15:0] handle;
   } slot_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_ADDR,
      CTL_EXEC
   } ctl_state_type;

endpackage

// ===== hdl/rtpjb_seq_mod.sv =====
// Slot index unit: sequence number modulo SLOTS by reciprocal multiply.
// Product registered at load, remainder formed from the registered product.
// Standalone; no package dependency.
module rtpjb_seq_mod #(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic [15:0]              operand,
   output logic [$clog2(SLOTS)-1:0] rem
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int K     = 16 + IDX_W;
   localparam int MW    = 18;
   localparam int PW    = 16 + MW;
   localparam longint unsigned RECIP = ((64'd1 << K) + SLOTS - 1) / SLOTS;

   logic [PW-1:0] prod_ff;
   logic [15:0]   opnd_ff;
   logic [PW-1:0] q_full;
   logic [15:0]   quot;
   logic [16:0]   r_full;
   logic [16:0]   r_adj;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PW'(operand) * PW'(RECIP);
         opnd_ff <= operand;
      end
   end

   always_comb begin
      q_full = prod_ff >> K;
      quot   = q_full[15:0];
      r_full = {1'b0, opnd_ff} - 17'(32'(quot) * SLOTS);
      // correct a quotient that came out one short
      if (r_full >= 17'(SLOTS)) begin
         r_adj = r_full - 17'(SLOTS);
      end else begin
         r_adj = r_full;
      end
      rem = IDX_W'(r_adj);
   end

endmodule

// ===== hdl/rtp_reorder_jitter_buffer_unit.sv =====
// RTP reorder jitter buffer, descriptor level. Top level.
// Depends on rtpjb_pkg and rtpjb_seq_mod.
//
// Usage:
//   Input transactions (arrival, pull, restart) are taken at an edge with start
//   high and busy low. busy then stays high through the ADDR state, which forms the
//   slot index (seq or expected seq modulo SLOTS, reciprocal multiply) and reads
//   the slot memory, and the EXEC state, which evaluates and writes back at its end.
//   The result shows on rsp_data for exactly one cycle with rsp_strobe high,
//   registered from the EXEC state. busy is already low in that cycle, so a new
//   transaction can be taken then, but not while the previous one is in flight.
//   The receiver cannot stall; every result is taken in its strobe cycle.
//   Slot descriptors live in a SLOTS-entry memory; valid bits are flops, so a
//   reanchor or restart clears all slots at once. Accesses never overlap:
//   the write of one transaction ends before the next one reads.
//   csr_data writes the enable bit; csr_ready is always high.
//   Reset (synchronous, active high) clears enable, the anchor, the expected
//   sequence number, the fill count and all valid bits. No clearing pass.
module rtp_reorder_jitter_buffer_unit #(
   parameter int SLOTS       = 16,
   parameter int PAYLOAD_MAX = 1500
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rtpjb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rtpjb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   rtpjb_pkg::ctl_state_type state_ff, state_in;

   logic                 enable_ff;
   logic                 anchored_ff, anchored_in;
   logic [15:0]          expected_ff, expected_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   rtpjb_pkg::req_type   req_ff;
   rtpjb_pkg::slot_type  rd_ff;
   logic [IDX_W-1:0]     idx_ff;
   rtpjb_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   rtpjb_pkg::slot_type  slot_mem [SLOTS];
   rtpjb_pkg::slot_type  wdata;
   logic                 mem_we;

   logic                 accept;
   logic [15:0]          mod_operand;
   logic [IDX_W-1:0]     mod_rem;

   logic [15:0]          exp_eff;
   logic [15:0]          seq_gap;
   logic                 len_bad;
   logic                 hit;
   logic [8:0]           count_ext;

   assign busy      = (state_ff != rtpjb_pkg::CTL_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // pulls index by the expected seq, everything else by the item's seq
   assign mod_operand = (req_data.kind == rtpjb_pkg::KIND_PULL) ? expected_ff : req_data.seq;

   rtpjb_seq_mod #(
      .SLOTS(SLOTS)
   ) u_seq_mod (
      .clock  (clock),
      .load   (accept),
      .operand(mod_operand),
      .rem    (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtpjb_pkg::CTL_IDLE;
         enable_ff    <= 1'b0;
         anchored_ff  <= 1'b0;
         expected_ff  <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         anchored_ff  <= anchored_in;
         expected_ff  <= expected_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == rtpjb_pkg::CTL_ADDR) begin
         rd_ff  <= slot_mem[mod_rem];
         idx_ff <= mod_rem;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[idx_ff] <= wdata;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtpjb_pkg::CTL_IDLE: begin
            if (start) begin
               state_in = rtpjb_pkg::CTL_ADDR;
            end
         end
         rtpjb_pkg::CTL_ADDR: begin
            state_in = rtpjb_pkg::CTL_EXEC;
         end
         rtpjb_pkg::CTL_EXEC: begin
            state_in = rtpjb_pkg::CTL_IDLE;
         end
         default: begin
            state_in = rtpjb_pkg::CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      anchored_in  = anchored_ff;
      expected_in  = expected_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      wdata.seq    = req_ff.seq;
      wdata.len    = req_ff.payload_len[10:0];
      wdata.handle = req_ff.payload_handle;

      exp_eff = anchored_ff ? expected_ff : req_ff.seq;
      seq_gap = req_ff.seq - exp_eff;
      len_bad = (req_ff.payload_len == 12'd0) || (req_ff.payload_len > 12'(PAYLOAD_MAX));
      hit     = 1'b0;

      rsp_in.status     = rtpjb_pkg::STATUS_NOTHING;
      rsp_in.out_seq    = '0;
      rsp_in.out_len    = '0;
      rsp_in.out_handle = '0;

      if (state_ff == rtpjb_pkg::CTL_EXEC) begin
         rsp_valid_in = 1'b1;
         case (req_ff.kind)
            rtpjb_pkg::KIND_ARRIVAL: begin
               if (enable_ff) begin
                  rsp_in.out_seq = req_ff.seq;
                  if (len_bad) begin
                     rsp_in.status = rtpjb_pkg::STATUS_INVALID;
                  end else begin
                     anchored_in = 1'b1;
                     expected_in = exp_eff;
                     if (seq_gap[15]) begin
                        rsp_in.status = rtpjb_pkg::STATUS_LATE;
                     end else if (seq_gap >= 16'(SLOTS)) begin
                        // too far ahead: drop every slot and anchor on this one
                        expected_in      = req_ff.seq;
                        valid_in         = '0;
                        valid_in[idx_ff] = 1'b1;
                        count_in         = CNT_W'(1);
                        mem_we           = 1'b1;
                        rsp_in.status    = rtpjb_pkg::STATUS_REANCHOR;
                     end else if (valid_ff[idx_ff] && (rd_ff.seq == req_ff.seq)) begin
                        rsp_in.status = rtpjb_pkg::STATUS_DUP;
                     end else begin
                        if (!valid_ff[idx_ff]) begin
                           count_in = count_ff + CNT_W'(1);
                        end
                        valid_in[idx_ff] = 1'b1;
                        mem_we           = 1'b1;
                        rsp_in.status    = rtpjb_pkg::STATUS_STORED;
                     end
                  end
               end
            end
            rtpjb_pkg::KIND_PULL: begin
               hit = valid_ff[idx_ff] && (rd_ff.seq == expected_ff);
               if (!anchored_ff) begin
                  rsp_in.status = rtpjb_pkg::STATUS_NOTHING;
               end else if (hit) begin
                  valid_in[idx_ff] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  expected_in       = expected_ff + 16'd1;
                  rsp_in.status     = rtpjb_pkg::STATUS_DELIVER;
                  rsp_in.out_seq    = expected_ff;
                  rsp_in.out_len    = rd_ff.len;
                  rsp_in.out_handle = rd_ff.handle;
               end else if (count_ff != '0) begin
                  // conceal: advance past the gap, keep the queue
                  expected_in    = expected_ff + 16'd1;
                  rsp_in.status  = rtpjb_pkg::STATUS_CONCEAL;
                  rsp_in.out_seq = expected_ff;
               end else begin
                  rsp_in.status = rtpjb_pkg::STATUS_NOTHING;
               end
            end
            rtpjb_pkg::KIND_RESTART: begin
               anchored_in   = 1'b0;
               expected_in   = '0;
               count_in      = '0;
               valid_in      = '0;
               rsp_in.status = rtpjb_pkg::STATUS_CLEARED;
            end
            default: begin
               rsp_in.status = rtpjb_pkg::STATUS_NOTHING;
            end
         endcase
      end

      count_ext     = 9'(count_in);
      rsp_in.queued = count_ext[4:0];
   end

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == rtpjb_pkg::CTL_EXEC))
      else $error("result strobe without an evaluate cycle");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(valid_ff))
      else $error("fill count differs from number of valid slots");

   a_accept_starts_index: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == rtpjb_pkg::CTL_ADDR))
      else $error("accepted transaction did not enter index stage");

   a_unanchored_empty: assert property (@(posedge clock) disable iff (reset)
      !anchored_ff |-> (count_ff == '0))
      else $error("slots queued while not anchored");

endmodule
